@@ hdl/b64e_pkg.sv @@
package b64e_pkg;

  // Depth of the record queue between front and back
  localparam int B64E_QDEPTH = 4;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // One encoded request: up to two 6-bit symbols, then '=' padding up to count
  typedef struct packed {
    logic [2:0] count;    // characters in this record, 1 to 4
    logic       two_sym;  // sym1 is a real symbol
    logic [5:0] sym0;
    logic [5:0] sym1;
    logic       last;     // final character closes the message
  } b64e_rec_t;

  // Map a 6-bit symbol onto the standard alphabet
  function automatic logic [6:0] b64e_alpha(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      return w + 7'd65;
    end else if (v < 6'd52) begin
      return w + 7'd71;
    end else if (v < 6'd62) begin
      return w - 7'd4;
    end else if (v == 6'd62) begin
      return 7'h2B;
    end else begin
      return 7'h2F;
    end
  endfunction

endpackage

@@ hdl/b64e_front.sv @@
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output b64e_rec_t  rec
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  always_comb begin
    rec       = '0;
    phase_nxt = PH_FIRST;
    carry_nxt = '0;
    case (phase_r)
      PH_SECOND: begin
        rec.sym0 = {carry_r[1:0], data_byte[7:4]};
        if (final_byte) begin
          rec.sym1    = {data_byte[3:0], 2'b00};
          rec.two_sym = 1'b1;
          rec.count   = 3'd3;
          rec.last    = 1'b1;
        end else begin
          rec.count = 3'd1;
          phase_nxt = PH_THIRD;
          carry_nxt = data_byte[3:0];
        end
      end
      PH_THIRD: begin
        rec.sym0    = {carry_r, data_byte[7:6]};
        rec.sym1    = data_byte[5:0];
        rec.two_sym = 1'b1;
        rec.count   = 3'd2;
        rec.last    = final_byte;
      end
      default: begin
        // first byte of a group; the unused phase code behaves the same
        rec.sym0 = data_byte[7:2];
        if (final_byte) begin
          rec.sym1    = {data_byte[1:0], 4'b0000};
          rec.two_sym = 1'b1;
          rec.count   = 3'd4;
          rec.last    = 1'b1;
        end else begin
          rec.count = 3'd1;
          phase_nxt = PH_SECOND;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  a_phase_used: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_UNUSED) else $error("front reached unused group phase");

  a_carry_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIRST |-> carry_r == 4'd0) else $error("stale carry at group start");

endmodule

@@ hdl/b64e_queue.sv @@
module b64e_queue import b64e_pkg::*; #(
  parameter int QDEPTH = B64E_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  b64e_rec_t wr_rec,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output b64e_rec_t rd_rec
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  b64e_rec_t      mem_r [QDEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full     = (cnt_r == CW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_rec   = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH)) else $error("queue count over depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count lost a read");

endmodule

@@ hdl/b64e_back.sv @@
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  b64e_rec_t  rec,
  output logic       rec_take,
  output logic       out_valid,
  input  logic       out_take,
  output logic [6:0] out_char,
  output logic       out_last
);

  b64e_rec_t  cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       oval_r, oval_nxt;
  logic [6:0] ochar_r, ochar_nxt;
  logic       olast_r, olast_nxt;
  logic       out_load, at_end, cur_done;

  assign out_load = !oval_r || out_take;
  assign at_end   = ({1'b0, idx_r} == cur_r.count - 3'd1);
  assign cur_done = out_load && cur_valid_r && at_end;
  assign rec_take = rec_valid && (!cur_valid_r || cur_done);

  always_comb begin
    // pick the character at the current position of the record
    if (idx_r == 2'd0) begin
      ochar_nxt = b64e_alpha(cur_r.sym0);
    end else if (idx_r == 2'd1 && cur_r.two_sym) begin
      ochar_nxt = b64e_alpha(cur_r.sym1);
    end else begin
      ochar_nxt = PAD_CHAR;
    end
    olast_nxt = cur_r.last && at_end;

    oval_nxt = out_load ? cur_valid_r : oval_r;

    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (rec_take) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = '0;
    end else if (out_load && cur_valid_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      oval_r      <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      oval_r      <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      cur_r <= rec;
    end
    if (out_load && cur_valid_r) begin
      ochar_r <= ochar_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> ({1'b0, idx_r} < cur_r.count)) else $error("index past record end");

  a_rec_shape: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.count != 3'd0 && cur_r.count <= 3'd4))
    else $error("malformed record held");

endmodule

@@ hdl/base64_stream_encoder.sv @@
// Channel  | Ports                                    | Handshake
// ---------+------------------------------------------+-----------------------------
// input    | in_data_byte[7:0], in_final_byte         | push && !full takes a byte
// result   | out_char[6:0], out_last                  | pop && !empty takes a char
//
// A byte is taken in any cycle the record queue has room; the front encodes it at
// once. The back sends one character per cycle while pop is high, and a byte yields 1
// to 4 characters (about 4/3 on average); the output serializer sets the sustained rate.
// Reset (rst_n low, synchronous) empties the queue and the output stage and puts
// the encoder at the start of a group. With pop low the head character holds;
// once the queue fills, full rises until the back drains a request.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int QDEPTH = B64E_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_last
);

  b64e_rec_t front_rec;
  b64e_rec_t q_rec;
  logic      q_full;
  logic      q_valid;
  logic      q_take;
  logic      out_valid;
  logic      take;

  // accept a request only when the queue has a slot for its record
  assign take = push && !q_full;
  assign full = q_full;

  // classify the byte against the group phase and build its record
  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .rec        (front_rec)
  );

  // decouple the byte side from the character side
  b64e_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_rec   (front_rec),
    .full     (q_full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_rec   (q_rec)
  );

  // serialize each record into characters through a registered output
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_valid),
    .rec       (q_rec),
    .rec_take  (q_take),
    .out_valid (out_valid),
    .out_take  (pop),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  assign empty = !out_valid;

endmodule
